@@ hdl/bitmap_set_test_find_engine_defines.svh @@
// assertion macros shared by the bitmap engine modules
// expects clk and rst_n in the scope of each use
`ifndef BITMAP_SET_TEST_FIND_ENGINE_DEFINES_SVH
`define BITMAP_SET_TEST_FIND_ENGINE_DEFINES_SVH

// property that holds at every edge outside reset
`define BSTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define BSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bstf_pkg.sv @@
// types, constants and helper functions of the bitmap engine
// no dependencies; used by every module of the block
package bstf_pkg;

    localparam int WORD_BITS    = 32;
    localparam int WORD_LSB     = 5;
    localparam int CAPACITY_DEF = 65536;
    localparam int INDEX_W      = 16;
    localparam int SIZE_W       = 17;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_TEST      = 2'd1,
        OP_FIND_NEXT = 2'd2,
        OP_FIND_PREV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_PUT
    } ctrl_state_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] index;
        logic               bit_value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
        logic               status;
        logic [SIZE_W-1:0]  matching_count;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
        logic res_set;
        logic wr_en;
        logic clr_en;
        logic put;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic in_range;
        logic scan_done;
        logic clr_last;
        logic out_free;
    } stat_t;

    // index of the lowest set bit of a word
    function automatic logic [WORD_LSB-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_LSB-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                p = WORD_LSB'(i);
            end
        end
        return p;
    endfunction

    // index of the highest set bit of a word
    function automatic logic [WORD_LSB-1:0] highest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_LSB-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (w[i])
            begin
                p = WORD_LSB'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ hdl/bstf_ctrl.sv @@
// sequencer of the bitmap engine: clearing pass, accept, scan, result hand-off
// depends on bstf_pkg and the shared assertion macros
`include "bitmap_set_test_find_engine_defines.svh"

module bstf_ctrl
    import bstf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t status,
    output cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.in_range ? ST_EVAL : ST_PUT;
                end
            end
            ST_EVAL:
            begin
                if (status.op == OP_WRITE || status.op == OP_TEST || status.scan_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_EVAL:
            begin
                cmd.wr_en = (status.op == OP_WRITE);
                if (status.op == OP_WRITE || status.op == OP_TEST)
                begin
                    cmd.res_set = 1'b1;
                end
                else
                begin
                    cmd.res_set = status.scan_done;
                    cmd.advance = !status.scan_done;
                end
            end
            ST_PUT:
            begin
                cmd.put = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // an accepted beat always leaves the idle state
    `BSTF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_reg != ST_IDLE, "accept did not start work")

endmodule

@@ hdl/bstf_datapath.sv @@
// bitmap storage, item registers, word scan logic, counters and output register
// depends on bstf_pkg and the shared assertion macros
`include "bitmap_set_test_find_engine_defines.svh"

module bstf_datapath
    import bstf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  in_item_t          in_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  cmd_t              cmd,
    output stat_t             status,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item
);

    localparam int WORD_COUNT = CAPACITY / WORD_BITS;
    localparam int AW         = $clog2(WORD_COUNT);

    // bitmap words
    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    set_count_reg;
    logic [SIZE_W-1:0]    set_count_next;
    logic [AW-1:0]        clr_ptr_reg;
    logic [AW-1:0]        word_ptr_reg;
    logic                 first_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    op_t                  op_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic                 val_reg;
    logic                 res_found_reg;
    logic [INDEX_W-1:0]   res_pos_reg;
    logic                 res_status_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    logic [SIZE_W-1:0]    eff_size;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic [WORD_LSB-1:0]  bit_off;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] first_mask;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] hits;
    logic                 any_hit;
    logic                 last_word;
    logic [31:0]          word_end;
    logic [WORD_LSB-1:0]  rem;
    logic [WORD_LSB-1:0]  hit_bit;
    logic [INDEX_W-1:0]   match_pos;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 old_bit;
    logic                 mem_we;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 is_find;
    logic [SIZE_W-1:0]    match_cnt;

    // size register, writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            size_reg <= cfg_data;
        end
    end

    // size limited to capacity
    assign eff_size = (32'(size_reg) > 32'(CAPACITY)) ? SIZE_W'(CAPACITY) : size_reg;

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_item.op;
            idx_reg <= in_item.index;
            val_reg <= in_item.bit_value;
        end
    end

    // read address: start word on load, then one word up or down per step
    assign rd_en   = cmd.load || cmd.advance;
    assign rd_addr = cmd.load ? AW'(in_item.index >> WORD_LSB) :
                     (op_reg == OP_FIND_PREV) ? word_ptr_reg - AW'(1) :
                                                word_ptr_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            word_ptr_reg <= rd_addr;
            first_reg    <= cmd.load;
        end
    end

    // write port: clearing pass or read-modify-write of one bit
    assign bit_off  = idx_reg[WORD_LSB-1:0];
    assign bit_mask = WORD_BITS'(1) << bit_off;
    assign old_bit  = rdata_reg[bit_off];
    assign mem_we   = cmd.clr_en || cmd.wr_en;
    assign waddr    = cmd.clr_en ? clr_ptr_reg : word_ptr_reg;
    assign wdata    = cmd.clr_en ? '0 :
                      val_reg    ? (rdata_reg | bit_mask) : (rdata_reg & ~bit_mask);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // clearing pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_ptr_reg <= clr_ptr_reg + AW'(1);
        end
    end

    // set bit counter
    always_comb
    begin
        set_count_next = set_count_reg;
        if (cmd.wr_en)
        begin
            if (val_reg && !old_bit)
            begin
                set_count_next = set_count_reg + SIZE_W'(1);
            end
            else if (!val_reg && old_bit)
            begin
                set_count_next = set_count_reg - SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg <= '0;
        end
        else
        begin
            set_count_reg <= set_count_next;
        end
    end

    // word scan: candidate bits masked to the search window
    assign cand       = val_reg ? rdata_reg : ~rdata_reg;
    assign word_end   = (32'(word_ptr_reg) + 32'd1) << WORD_LSB;
    assign last_word  = word_end >= 32'(eff_size);
    assign rem        = eff_size[WORD_LSB-1:0];
    assign lim_mask   = (last_word && rem != '0) ? ~({WORD_BITS{1'b1}} << rem)
                                                 : {WORD_BITS{1'b1}};
    assign first_mask = !first_reg ? {WORD_BITS{1'b1}} :
                        (op_reg == OP_FIND_PREV) ?
                            ({WORD_BITS{1'b1}} >> (WORD_LSB'(WORD_BITS - 1) - bit_off)) :
                            ({WORD_BITS{1'b1}} << bit_off);
    assign hits       = (op_reg == OP_FIND_PREV) ? (cand & first_mask)
                                                 : (cand & first_mask & lim_mask);
    assign any_hit    = |hits;
    assign hit_bit    = (op_reg == OP_FIND_PREV) ? highest_set(hits) : lowest_set(hits);
    assign match_pos  = INDEX_W'({word_ptr_reg, hit_bit});
    assign is_find    = (op_reg == OP_FIND_NEXT) || (op_reg == OP_FIND_PREV);

    // pending result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_found_reg  <= 1'b0;
            res_pos_reg    <= in_item.index;
            res_status_reg <= !status.in_range;
        end
        else if (cmd.res_set)
        begin
            case (op_reg)
                OP_WRITE:
                begin
                    res_found_reg <= 1'b1;
                end
                OP_TEST:
                begin
                    res_found_reg <= old_bit;
                end
                default:
                begin
                    res_found_reg <= any_hit;
                end
            endcase
            if (is_find && any_hit)
            begin
                res_pos_reg <= match_pos;
            end
        end
    end

    // count of bits equal to the item value, clear count saturates at zero
    assign match_cnt = val_reg ? set_count_reg :
                       (eff_size > set_count_reg) ? (eff_size - set_count_reg) : '0;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            out_item_reg.found          <= res_found_reg;
            out_item_reg.position       <= res_pos_reg;
            out_item_reg.status         <= res_status_reg;
            out_item_reg.matching_count <= match_cnt;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // status to the controller
    assign status.op        = op_reg;
    assign status.in_range  = {1'b0, in_item.index} < eff_size;
    assign status.scan_done = any_hit ||
                              ((op_reg == OP_FIND_PREV) ? (word_ptr_reg == '0) : last_word);
    assign status.clr_last  = clr_ptr_reg == AW'(WORD_COUNT - 1);
    assign status.out_free  = !out_valid_reg || !out_stall;

    // counter never exceeds the storage
    `BSTF_ASSERT(a_count_bound, 32'(set_count_reg) <= 32'(CAPACITY), "set count above capacity")
    // rejected index never reports a hit
    `BSTF_ASSERT(a_reject_clean, !(out_valid_reg && out_item_reg.status && out_item_reg.found), "out of range beat with found set")
    // counter moves only on a bit write
    `BSTF_ASSERT(a_count_write, (set_count_reg == $past(set_count_reg)) || $past(cmd.wr_en), "set count changed without a write")

endmodule

@@ hdl/bitmap_set_test_find_engine.sv @@
// After an accepted beat, a rejected index goes straight to ST_PUT, a write or test
// passes through ST_EVAL to ST_PUT, and a find stays in ST_EVAL while it reads words;
// the single memory read port scans one 32-bit word per cycle. Next beat is taken in
// the cycle after the result moves into the output register.
// After reset a clearing pass zeroes CAPACITY/32 words with in_stall high; size register
// writes are taken throughout. Size resets to 65536.
module bitmap_set_test_find_engine
    import bstf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t status;

    // sequencer
    bstf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and scan logic
    bstf_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
